/* hw/rtl/gisb_pkg.sv */
`default_nettype none

package gisb_pkg;

    // Field widths fixed by the interface
    localparam int VTX_W   = 10;
    localparam int LABEL_W = 11;
    localparam int CMD_W   = 2;

    // Default sizes
    localparam int DEF_MAX_VERTICES  = 1024;
    localparam int DEF_MAX_NEIGHBORS = 16;

    // Register reset and label limits
    localparam logic [LABEL_W-1:0] VCOUNT_RESET = 11'd1024;
    localparam logic [LABEL_W-1:0] LABEL_FIRST  = 11'd1;
    localparam logic [LABEL_W-1:0] LABEL_LAST   = 11'd2047;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Reply kinds
    localparam logic REPLY_VISIT = 1'b0;
    localparam logic REPLY_READ  = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/gisb_label_mem.sv */
`default_nettype none

module gisb_label_mem
    import gisb_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_VERTICES,
    parameter int AW    = $clog2(DEF_MAX_VERTICES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [LABEL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [LABEL_W-1:0] o_rdata
);

    logic [LABEL_W-1:0] r_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/greedy_independent_set_blocking.sv */
`default_nettype none

// Greedy independent-set blocking. Send each visited vertex as a run of
// neighbor entries on the input channel, last entry marked; the marked entry
// returns one decision (seed flag, block label, unassigned count, overflow).
// A label read returns one reply; a clear returns nothing. All work goes
// through one label memory (a write port and a registered read port),
// stepped by a small sequencer, and the block takes no item while it runs.
// A neighbor entry that is not last passes the check state; a last entry
// also passes the decision state and, when the vertex becomes a seed, a
// read and a write per buffered neighbor; a label read passes a read
// state. After reset and after each clear command the label memory is
// swept to zero, one entry per cycle, and no item is taken during the
// sweep (configuration writes are always taken). A result moves to the
// output register in the last cycle of its item; while an earlier result
// still waits there, the sequencer holds in that cycle and takes no new
// item. Up to MAX_NEIGHBORS neighbors per vertex are buffered; a longer
// list is flagged as overflow and the vertex is not chosen.

module greedy_independent_set_blocking
    import gisb_pkg::*;
#(
    parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
    parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LABEL_W-1:0] i_cfg_data,
    // Input items
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [CMD_W-1:0]   i_command,
    input  wire logic [VTX_W-1:0]   i_vertex,
    input  wire logic [VTX_W-1:0]   i_neighbor,
    input  wire logic               i_neighbor_valid,
    input  wire logic               i_last_neighbor,
    // Results
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_reply_kind,
    output logic                    o_is_seed,
    output logic      [LABEL_W-1:0] o_label,
    output logic      [LABEL_W-1:0] o_unassigned,
    output logic                    o_overflow
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    localparam int BW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_VERTICES - 1);
    localparam logic [CW-1:0] NB_FULL   = CW'(MAX_NEIGHBORS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_VTX,
        S_NRD,
        S_NWR,
        S_RDLBL,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [LABEL_W-1:0] r_vertex_count;
    logic [LABEL_W-1:0] r_unassigned;
    logic [LABEL_W-1:0] r_next_label;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_k;
    logic               r_cand;
    logic               r_ovf;
    logic [VTX_W-1:0]   r_vtx;
    logic               r_vtx_ok;
    logic               r_last;
    logic               r_nb_used;
    logic [AW-1:0]      r_wr_addr;
    logic [AW-1:0]      r_nbuf [MAX_NEIGHBORS];
    logic [AW-1:0]      r_buf_q;
    logic               r_res_kind;
    logic               r_res_seed;
    logic [LABEL_W-1:0] r_res_label;
    logic               r_res_ovf;
    logic               r_out_valid;
    logic               r_out_kind;
    logic               r_out_seed;
    logic [LABEL_W-1:0] r_out_label;
    logic [LABEL_W-1:0] r_out_unassigned;
    logic               r_out_ovf;

    logic               w_accept;
    logic               w_vtx_in;
    logic               w_nb_in;
    logic               w_nb_take;
    logic               w_seed;
    logic               w_out_free;
    logic [CW-1:0]      w_k_inc;
    logic [BW-1:0]      w_bra;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_wa;
    logic [LABEL_W-1:0] w_mem_wd;
    logic [AW-1:0]      w_mem_ra;
    logic [LABEL_W-1:0] w_mem_rd;
    logic [LABEL_W-1:0] w_unassigned_dec;
    logic [LABEL_W-1:0] w_label_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_vtx_in  = (32'(i_vertex) < MAX_VERTICES);
    assign w_nb_in   = (32'(i_neighbor) < MAX_VERTICES);
    assign w_nb_take = i_neighbor_valid && w_nb_in;
    assign w_seed    = r_cand && !r_ovf && r_vtx_ok && (w_mem_rd == '0);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_unassigned_dec = (r_unassigned != '0) ? (r_unassigned - 1'b1) : '0;
    assign w_label_inc = (r_next_label != LABEL_LAST) ? (r_next_label + 1'b1) : LABEL_LAST;

    // Step through buffered neighbors, wrapping to the first at the end
    assign w_k_inc = r_k + CW'(1);
    always_comb begin
        if (r_state == S_VTX || w_k_inc >= r_count) begin
            w_bra = '0;
        end else begin
            w_bra = w_k_inc[BW-1:0];
        end
    end

    // Select the label memory address and write
    always_comb begin
        w_mem_we = 1'b0;
        w_mem_wa = r_wr_addr;
        w_mem_wd = r_res_label;
        case (r_state)
            S_IDLE:  w_mem_ra = (i_command == CMD_READ) ? AW'(i_vertex) : AW'(i_neighbor);
            S_CHK:   w_mem_ra = AW'(r_vtx);
            S_NRD:   w_mem_ra = r_buf_q;
            default: w_mem_ra = '0;
        endcase
        case (r_state)
            S_CLEAR: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_clr_addr;
                w_mem_wd = '0;
            end
            S_VTX: begin
                w_mem_we = w_seed;
                w_mem_wa = AW'(r_vtx);
                w_mem_wd = r_next_label;
            end
            S_NWR: begin
                w_mem_we = 1'b1;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    gisb_label_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_label_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_wa),
        .i_wdata (w_mem_wd),
        .i_raddr (w_mem_ra),
        .o_rdata (w_mem_rd)
    );

    // Neighbor buffer: fill during a run, read back one entry per step
    always_ff @(posedge i_clk) begin
        if (w_accept && i_command == CMD_ENTRY && w_nb_take && r_count != NB_FULL) begin
            r_nbuf[r_count[BW-1:0]] <= AW'(i_neighbor);
        end
        r_buf_q <= r_nbuf[w_bra];
    end

    // Sequencer, run state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_vertex_count <= VCOUNT_RESET;
            r_unassigned   <= VCOUNT_RESET;
            r_next_label   <= LABEL_FIRST;
            r_count        <= '0;
            r_k            <= '0;
            r_cand         <= 1'b1;
            r_ovf          <= 1'b0;
            r_last         <= 1'b0;
            r_nb_used      <= 1'b0;
            r_vtx_ok       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // drop the result once transferred
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (w_accept) begin
                        case (i_command)
                            CMD_CLEAR: begin
                                r_state      <= S_CLEAR;
                                r_clr_addr   <= '0;
                                r_next_label <= LABEL_FIRST;
                                r_unassigned <= r_vertex_count;
                                r_count      <= '0;
                                r_cand       <= 1'b1;
                                r_ovf        <= 1'b0;
                            end
                            CMD_ENTRY: begin
                                r_state   <= S_CHK;
                                r_vtx     <= i_vertex;
                                r_vtx_ok  <= w_vtx_in;
                                r_last    <= i_last_neighbor;
                                r_nb_used <= w_nb_take;
                                if (w_nb_take) begin
                                    if (r_count != NB_FULL) begin
                                        r_count <= r_count + 1'b1;
                                    end else begin
                                        r_ovf <= 1'b1;
                                    end
                                end
                            end
                            CMD_READ: begin
                                r_state  <= S_RDLBL;
                                r_vtx_ok <= w_vtx_in;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_CHK: begin
                    // a labeled neighbor rules the vertex out
                    if (r_nb_used && w_mem_rd != '0) begin
                        r_cand <= 1'b0;
                    end
                    r_state <= r_last ? S_VTX : S_IDLE;
                end

                S_VTX: begin
                    r_res_kind <= REPLY_VISIT;
                    r_res_seed <= w_seed;
                    r_res_ovf  <= r_ovf;
                    r_cand     <= 1'b1;
                    r_ovf      <= 1'b0;
                    r_k        <= '0;
                    if (w_seed) begin
                        r_res_label  <= r_next_label;
                        r_next_label <= w_label_inc;
                        r_unassigned <= w_unassigned_dec;
                        if (r_count != '0) begin
                            r_state <= S_NRD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_res_label <= '0;
                        r_count     <= '0;
                        r_state     <= S_OUT;
                    end
                end

                S_NRD: begin
                    r_wr_addr <= r_buf_q;
                    r_state   <= S_NWR;
                end

                S_NWR: begin
                    if (w_mem_rd == '0) begin
                        r_unassigned <= w_unassigned_dec;
                    end
                    if (w_k_inc == r_count) begin
                        r_count <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= w_k_inc;
                        r_state <= S_NRD;
                    end
                end

                S_RDLBL: begin
                    r_res_kind  <= REPLY_READ;
                    r_res_seed  <= 1'b0;
                    r_res_ovf   <= 1'b0;
                    r_res_label <= r_vtx_ok ? w_mem_rd : '0;
                    r_state     <= S_OUT;
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_kind       <= r_res_kind;
                        r_out_seed       <= r_res_seed;
                        r_out_label      <= r_res_label;
                        r_out_unassigned <= r_unassigned;
                        r_out_ovf        <= r_res_ovf;
                        r_state          <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register write reloads the unassigned count
            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_data;
                r_unassigned   <= i_cfg_data;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reply_kind = r_out_kind;
    assign o_is_seed    = r_out_seed;
    assign o_label      = r_out_label;
    assign o_unassigned = r_out_unassigned;
    assign o_overflow   = r_out_ovf;

    // Buffer fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NB_FULL)
        else $error("neighbor count beyond buffer depth");

    // Label counter never returns to the unassigned code
    a_label_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_label != '0)
        else $error("next label is zero");

    // Unassigned count never rises above the configured vertex count
    a_unassigned_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unassigned <= r_vertex_count)
        else $error("unassigned count above vertex count");

    // A seed decision carries a real label and no overflow
    a_seed_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_seed) |-> (o_label != '0 && !o_overflow &&
                                        o_reply_kind == REPLY_VISIT))
        else $error("seed result with bad label or flags");

    // Labels change only while the sequencer works on a seed or a sweep
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_VTX || r_state == S_NWR))
        else $error("label write outside sweep or seed labeling");

endmodule

`default_nettype wire
